// File: rtl/core/cdnw_pkg.sv
// ----------------------------------------------------------------------------
// cdnw_pkg
// Shared types, constants and tables for the calendar date neighbours and
// weekday unit.
// ----------------------------------------------------------------------------
package cdnw_pkg;

   localparam int DayW   = 5;
   localparam int MonthW = 4;
   localparam int YearW  = 14;
   localparam int CentW  = 7;
   localparam int WdayW  = 3;

   localparam int ReqDataW = 24;
   localparam int RspDataW = 56;

   localparam int QueueDepthDefault = 2;

   localparam logic [YearW-1:0] YearMax = YearW'(9999);
   localparam logic [MonthW-1:0] MonthDec = MonthW'(12);
   localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
   localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
   localparam logic [MonthW-1:0] MonthMar = MonthW'(3);

   // y / 100 as (y * 5243) >> 19, exact for y below 43699
   localparam int DivHundredMul   = 5243;
   localparam int DivHundredShift = 19;
   localparam int Hundred         = 100;

   // x / 7 as (x * 2341) >> 14, exact for the zeller sum range
   localparam int ModSevenMul   = 2341;
   localparam int ModSevenShift = 14;
   localparam int Seven         = 7;

   typedef struct packed {
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
      logic [YearW-1:0]  year_z;
      logic [CentW-1:0]  cent_y;
      logic [CentW-1:0]  cent_z;
   } entry_type;

   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
      logic [DayW-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayW'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = DayW'(30);
         4'd2:                                       len = leap ? DayW'(29) : DayW'(28);
         default:                                    len = '0;
      endcase
      return len;
   endfunction

   // (13 * (m + 1)) / 5 for the shifted month 3..14
   function automatic logic [5:0] zeller_month_term(input logic [MonthW-1:0] m);
      logic [5:0] t;
      case (m)
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         4'd13:   t = 6'd36;
         4'd14:   t = 6'd39;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

endpackage

// File: rtl/core/cdnw_front.sv
// ----------------------------------------------------------------------------
// cdnw_front
// Unpacks a date request, shifts january and february into the previous
// year for zeller, and finds the century of both years.
// ----------------------------------------------------------------------------
module cdnw_front (
   input  logic [cdnw_pkg::ReqDataW-1:0] req_tdata,
   output cdnw_pkg::entry_type           entry
);

   localparam int ProdW = cdnw_pkg::YearW + 13;

   logic [cdnw_pkg::DayW-1:0]   day;
   logic [cdnw_pkg::MonthW-1:0] month;
   logic [cdnw_pkg::YearW-1:0]  year;
   logic [cdnw_pkg::YearW-1:0]  year_z;
   logic [ProdW-1:0]            prod_y;
   logic [ProdW-1:0]            prod_z;

   assign day   = req_tdata[4:0];
   assign month = req_tdata[8:5];
   assign year  = req_tdata[22:9];

   assign year_z = (month < cdnw_pkg::MonthMar) ? year - cdnw_pkg::YearW'(1) : year;

   assign prod_y = ProdW'(year) * ProdW'(cdnw_pkg::DivHundredMul);
   assign prod_z = ProdW'(year_z) * ProdW'(cdnw_pkg::DivHundredMul);

   always_comb begin
      entry.day    = day;
      entry.month  = month;
      entry.year   = year;
      entry.year_z = year_z;
      entry.cent_y = prod_y[cdnw_pkg::DivHundredShift +: cdnw_pkg::CentW];
      entry.cent_z = prod_z[cdnw_pkg::DivHundredShift +: cdnw_pkg::CentW];
   end

endmodule

// File: rtl/core/cdnw_queue.sv
// ----------------------------------------------------------------------------
// cdnw_queue
// Small fifo between the front and back halves.
// ----------------------------------------------------------------------------
module cdnw_queue #(
   parameter int Depth = cdnw_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cdnw_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output cdnw_pkg::entry_type head
);

   localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cdnw_pkg::entry_type store_ff [Depth];
   logic [IdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(Depth - 1)) ? '0 : wr_ptr_ff + IdxW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(Depth - 1)) ? '0 : rd_ptr_ff + IdxW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count above depth");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> !full)
      else $error("push into full queue");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("queue count did not advance");
`endif

endmodule

// File: rtl/core/cdnw_back.sv
// ----------------------------------------------------------------------------
// cdnw_back
// Checks the date, forms the following and preceding dates and the zeller
// weekday, and holds the response in an output register.
// ----------------------------------------------------------------------------
module cdnw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          entry_valid,
   input  cdnw_pkg::entry_type           entry,
   output logic                          entry_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cdnw_pkg::RspDataW-1:0] rsp_tdata,
   output logic                          rsp_tuser
);

   localparam int SumW  = 10;
   localparam int ProdW = SumW + 12;

   logic [cdnw_pkg::YearW-1:0]  rem_y;
   logic [cdnw_pkg::YearW-1:0]  rem_z_full;
   logic [cdnw_pkg::CentW-1:0]  rem_z;
   logic                        leap;
   logic [cdnw_pkg::DayW-1:0]   mlen;
   logic                        bad;
   logic [cdnw_pkg::MonthW-1:0] month_z;
   logic [SumW-1:0]             zsum;
   logic [ProdW-1:0]            zprod;
   logic [SumW-1:0]             zquot;
   logic [SumW-1:0]             zrem;

   logic [cdnw_pkg::DayW-1:0]   nd, pd;
   logic [cdnw_pkg::MonthW-1:0] nm, pm;
   logic [cdnw_pkg::YearW-1:0]  ny, py;
   logic [cdnw_pkg::WdayW-1:0]  wd;

   logic                         valid_ff, valid_in;
   logic [cdnw_pkg::DayW-1:0]    nd_ff, pd_ff;
   logic [cdnw_pkg::MonthW-1:0]  nm_ff, pm_ff;
   logic [cdnw_pkg::YearW-1:0]   ny_ff, py_ff;
   logic [cdnw_pkg::WdayW-1:0]   wd_ff;
   logic                         bad_ff;

   assign entry_pop = entry_valid && (!valid_ff || rsp_tready);

   // leap year from the century split
   assign rem_y = entry.year - cdnw_pkg::YearW'(entry.cent_y) *
                  cdnw_pkg::YearW'(cdnw_pkg::Hundred);
   assign leap  = (entry.year[1:0] == 2'b00) &&
                  ((rem_y != '0) || (entry.cent_y[1:0] == 2'b00));
   assign mlen  = cdnw_pkg::month_len(entry.month, leap);

   assign bad = (entry.month == '0) || (entry.month > cdnw_pkg::MonthDec) ||
                (entry.year == '0) || (entry.year > cdnw_pkg::YearMax) ||
                (entry.day == '0) || (entry.day > mlen);

   // zeller congruence
   assign month_z    = (entry.month < cdnw_pkg::MonthMar) ?
                       entry.month + cdnw_pkg::MonthW'(12) : entry.month;
   assign rem_z_full = entry.year_z - cdnw_pkg::YearW'(entry.cent_z) *
                       cdnw_pkg::YearW'(cdnw_pkg::Hundred);
   assign rem_z      = rem_z_full[cdnw_pkg::CentW-1:0];
   assign zsum  = SumW'(entry.day) + SumW'(cdnw_pkg::zeller_month_term(month_z)) +
                  SumW'(rem_z) + SumW'(rem_z >> 2) + SumW'(entry.cent_z >> 2) +
                  SumW'(entry.cent_z) * SumW'(5);
   assign zprod = ProdW'(zsum) * ProdW'(cdnw_pkg::ModSevenMul);
   assign zquot = zprod[cdnw_pkg::ModSevenShift +: SumW];
   assign zrem  = zsum - zquot * SumW'(cdnw_pkg::Seven);
   assign wd    = zrem[cdnw_pkg::WdayW-1:0];

   // following and preceding dates
   always_comb begin
      nd = entry.day + cdnw_pkg::DayW'(1);
      nm = entry.month;
      ny = entry.year;
      if (entry.day == mlen) begin
         nd = cdnw_pkg::DayW'(1);
         if (entry.month == cdnw_pkg::MonthDec) begin
            nm = cdnw_pkg::MonthJan;
            ny = entry.year + cdnw_pkg::YearW'(1);
         end else begin
            nm = entry.month + cdnw_pkg::MonthW'(1);
         end
      end
      pd = entry.day - cdnw_pkg::DayW'(1);
      pm = entry.month;
      py = entry.year;
      if (entry.day == cdnw_pkg::DayW'(1)) begin
         if (entry.month == cdnw_pkg::MonthJan) begin
            pm = cdnw_pkg::MonthDec;
            py = entry.year - cdnw_pkg::YearW'(1);
            pd = cdnw_pkg::DayW'(31);
         end else begin
            pm = entry.month - cdnw_pkg::MonthW'(1);
            pd = cdnw_pkg::month_len(pm, leap);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (entry_pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_pop) begin
         bad_ff <= bad;
         nd_ff  <= bad ? '0 : nd;
         nm_ff  <= bad ? '0 : nm;
         ny_ff  <= bad ? '0 : ny;
         pd_ff  <= bad ? '0 : pd;
         pm_ff  <= bad ? '0 : pm;
         py_ff  <= bad ? '0 : py;
         wd_ff  <= bad ? '0 : wd;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = bad_ff;
   assign rsp_tdata  = {7'b0, wd_ff, py_ff, pm_ff, pd_ff, ny_ff, nm_ff, nd_ff};

`ifndef SYNTHESIS
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && bad_ff) |-> (rsp_tdata == '0))
      else $error("invalid date with nonzero fields");

   a_wday_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (wd_ff <= cdnw_pkg::WdayW'(6)))
      else $error("weekday out of range");

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      entry_pop |=> valid_ff)
      else $error("popped entry not presented");

   a_good_days: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !bad_ff) |-> (nd_ff != '0 && pd_ff != '0))
      else $error("valid date with zero day");
`endif

endmodule

// File: rtl/core/calendar_date_neighbours_weekday_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_neighbours_weekday_unit
// Gregorian following date, preceding date and zeller weekday of a date.
// ----------------------------------------------------------------------------
// path: request accept writes the queue, then the pop loads the single back
//   half result register that drives rsp_tvalid; low rsp_tready stalls the pop
// throughput: one request per cycle while rsp_tready is high
// reset: clears the queue pointers and count and the response valid flag
// ----------------------------------------------------------------------------
module calendar_date_neighbours_weekday_unit #(
   parameter int QueueDepth = cdnw_pkg::QueueDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // day [4:0], month [8:5], year [22:9]
   input  logic [cdnw_pkg::ReqDataW-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // next_day [4:0], next_month [8:5], next_year [22:9], prev_day [27:23],
   // prev_month [31:28], prev_year [45:32], weekday [48:46]
   output logic [cdnw_pkg::RspDataW-1:0] rsp_tdata,
   // invalid [0]
   output logic                          rsp_tuser
);

   cdnw_pkg::entry_type front_entry;
   cdnw_pkg::entry_type head_entry;
   logic                q_full;
   logic                q_not_empty;
   logic                q_pop;
   logic                q_push;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   cdnw_front u_front (
      .req_tdata (req_tdata),
      .entry     (front_entry)
   );

   cdnw_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (head_entry)
   );

   cdnw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (q_not_empty),
      .entry       (head_entry),
      .entry_pop   (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
